### hw/rtl/twq_pkg.sv
// ----------------------------------------------------------------------------
// twq_pkg
// Types and constants shared by the timed wait queue modules.
// ----------------------------------------------------------------------------
package twq_pkg;

  localparam logic [29:0] NS_PER_SEC   = 30'd1000000000;
  localparam logic [30:0] NS_PER_2SEC  = 31'd2000000000;

  typedef enum logic [2:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_READY  = 3'd2,
    OP_BY_ID  = 3'd3,
    OP_WAIT   = 3'd4,
    OP_RSVD5  = 3'd5,
    OP_RSVD6  = 3'd6,
    OP_RSVD7  = 3'd7
  } twq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NONE  = 2'd2,
    ST_RSVD  = 2'd3
  } twq_status_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] proc_id;
    logic [31:0] time_seconds;
    logic [29:0] time_nanos;
    logic [7:0]  frame_index;
    logic [5:0]  page_num;
    logic        is_read;
    logic [29:0] elapsed_nanos;
  } twq_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [15:0] out_proc_id;
    logic [31:0] out_wake_seconds;
    logic [29:0] out_wake_nanos;
    logic [7:0]  out_frame_index;
    logic [5:0]  out_page_index;
    logic        out_is_read;
    logic [31:0] out_waited_seconds;
    logic [29:0] out_waited_nanos;
  } twq_rsp_t;

  typedef struct packed {
    logic [15:0] pid;
    logic [31:0] wake_sec;
    logic [29:0] wake_ns;
    logic [7:0]  frame;
    logic [5:0]  page;
    logic        rd;
    logic [31:0] wait_sec;
    logic [29:0] wait_ns;
  } twq_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_WAIT,
    S_DONE
  } twq_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, clear scan index
    logic enq;       // write request at tail
    logic step;      // advance scan index
    logic take;      // capture current entry as result, start gap closing
    logic shift;     // copy entry idx+1 into idx, advance
    logic wait_upd;  // update waited time of entry idx, advance
    logic dec;       // count minus one
    logic emit;      // present result
    logic [1:0] status;
  } twq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic     empty;
    logic     full;
    logic     last;    // idx is the final valid entry
    logic     hit;     // entry idx matches
    twq_op_e  op;
  } twq_sts_t;

endpackage

### hw/rtl/timed_wait_queue_unit.sv
// ----------------------------------------------------------------------------
// timed_wait_queue_unit
// Bounded FIFO of blocked memory requests with timed and by-id release.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_i and raise start; the transaction is taken at a clock edge
//   where busy is low. busy stays high until the result is out.
//   The result appears on rsp_o for exactly one cycle with valid_o high;
//   the receiver cannot stall it.
// Steps from the accepting edge to valid_o rising:
//   enqueue, operation on an empty queue, unused code: no scan steps
//   remove without a match: one entry compared per cycle to the tail
//   dequeue / remove with a match: the scan up to the match and the gap
//   closing to the tail step one entry a cycle, then the count drops by
//   one and the result is emitted from the done state.
//   add wait: one entry updated per cycle, result with the last update.
// busy falls as valid_o rises, so the next transaction can be taken at the
// edge that ends the result cycle.
// Reset empties the queue; entry contents are not cleared.
// ----------------------------------------------------------------------------
module timed_wait_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  twq_pkg::twq_req_t req_i,
  output logic              valid_o,
  output twq_pkg::twq_rsp_t rsp_o
);
  import twq_pkg::*;

  twq_cmd_t cmd;
  twq_sts_t sts;
  logic     busy_c;

  twq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy_c),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  twq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  assign busy = busy_c;

endmodule

### hw/rtl/twq_ctrl.sv
// ----------------------------------------------------------------------------
// twq_ctrl
// Sequencer for the timed wait queue: scan, gap closing and wait update.
// ----------------------------------------------------------------------------
module twq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  twq_pkg::twq_sts_t sts_i,
  output twq_pkg::twq_cmd_t cmd_o
);
  import twq_pkg::*;

  twq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        unique case (sts_i.op)
          OP_ENQ: begin
            cmd_o.emit = 1'b1;
            if (sts_i.full) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.enq    = 1'b1;
              cmd_o.status = ST_OK;
            end
            state_d = S_IDLE;
          end
          OP_DEQ, OP_READY, OP_BY_ID: begin
            if (sts_i.empty) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ST_NONE;
              state_d      = S_IDLE;
            end else if (sts_i.hit || sts_i.op == OP_DEQ) begin
              cmd_o.take = 1'b1;
              state_d    = S_SHIFT;
            end else if (sts_i.last) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ST_NONE;
              state_d      = S_IDLE;
            end else begin
              cmd_o.step = 1'b1;
            end
          end
          OP_WAIT: begin
            if (sts_i.empty) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ST_OK;
              state_d      = S_IDLE;
            end else begin
              state_d = S_WAIT;
            end
          end
          default: begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = ST_NONE;
            state_d      = S_IDLE;
          end
        endcase
      end
      S_SHIFT: begin
        if (sts_i.last) begin
          cmd_o.dec = 1'b1;
          state_d   = S_DONE;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      S_WAIT: begin
        cmd_o.wait_upd = 1'b1;
        if (sts_i.last) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = ST_OK;
          state_d      = S_IDLE;
        end
      end
      S_DONE: begin
        cmd_o.emit   = 1'b1;
        cmd_o.status = ST_OK;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### hw/rtl/twq_dp.sv
// ----------------------------------------------------------------------------
// twq_dp
// Entry store, scan index, match and waited-time arithmetic.
// ----------------------------------------------------------------------------
module twq_dp #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  twq_pkg::twq_req_t req_i,
  input  twq_pkg::twq_cmd_t cmd_i,
  output twq_pkg::twq_sts_t sts_o,
  output logic              valid_o,
  output twq_pkg::twq_rsp_t rsp_o
);
  import twq_pkg::*;

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // registers read at fixed places only through the idx mux; small queue
  twq_entry_t mem_q [QUEUE_DEPTH];
  twq_req_t   req_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] idx_q, idx_d;
  twq_entry_t    res_q;
  logic          found_q;
  logic          valid_q;
  twq_rsp_t      rsp_q, rsp_d;

  twq_entry_t cur, nxt, upd;
  logic [IW-1:0] idx_n;
  logic [CW-1:0] idx_ext;
  logic [30:0] ns_sum;
  logic [30:0] ns_sub;
  logic [32:0] sec_sum;
  logic [1:0]  carry;

  assign idx_ext = CW'(idx_q);
  assign idx_n   = (idx_ext + 1'b1 < CW'(QUEUE_DEPTH)) ? IW'(idx_ext + 1'b1) : idx_q;
  assign cur     = mem_q[idx_q];
  assign nxt     = mem_q[idx_n];

  // elapsed may exceed one second, so up to two seconds carry
  assign ns_sum  = {1'b0, cur.wait_ns} + {1'b0, req_q.elapsed_nanos};
  assign carry   = (ns_sum >= NS_PER_2SEC) ? 2'd2 :
                   (ns_sum >= {1'b0, NS_PER_SEC}) ? 2'd1 : 2'd0;
  assign ns_sub  = carry[1] ? NS_PER_2SEC : (carry[0] ? {1'b0, NS_PER_SEC} : 31'd0);
  assign sec_sum = {1'b0, cur.wait_sec} + 33'(carry);

  always_comb begin
    upd          = cur;
    upd.wait_ns  = 30'(ns_sum - ns_sub);
    upd.wait_sec = sec_sum[32] ? 32'hFFFF_FFFF : sec_sum[31:0];
  end

  assign sts_o.empty = (cnt_q == '0);
  assign sts_o.full  = (cnt_q >= CW'(QUEUE_DEPTH));
  assign sts_o.last  = (idx_ext + 1'b1 >= cnt_q);
  assign sts_o.op    = twq_op_e'(req_q.operation);
  assign sts_o.hit   = (req_q.operation == OP_READY) ?
                       ((cur.wake_sec < req_q.time_seconds) ||
                        (cur.wake_sec == req_q.time_seconds &&
                         cur.wake_ns <= req_q.time_nanos)) :
                       (cur.pid == req_q.proc_id);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (cmd_i.load) idx_d = '0;
    if (cmd_i.step || cmd_i.shift || cmd_i.wait_upd) idx_d = idx_n;
    if (cmd_i.enq) cnt_d = cnt_q + 1'b1;
    if (cmd_i.dec) cnt_d = cnt_q - 1'b1;
  end

  always_comb begin
    rsp_d        = '0;
    rsp_d.status = cmd_i.status;
    if (found_q && cmd_i.status == ST_OK && req_q.operation != OP_WAIT) begin
      rsp_d.found              = 1'b1;
      rsp_d.out_proc_id        = res_q.pid;
      rsp_d.out_wake_seconds   = res_q.wake_sec;
      rsp_d.out_wake_nanos     = res_q.wake_ns;
      rsp_d.out_frame_index    = res_q.frame;
      rsp_d.out_page_index     = res_q.page;
      rsp_d.out_is_read        = res_q.rd;
      rsp_d.out_waited_seconds = res_q.wait_sec;
      rsp_d.out_waited_nanos   = res_q.wait_ns;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      valid_q <= cmd_i.emit;
      if (cmd_i.load) found_q <= 1'b0;
      if (cmd_i.take) found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.take) res_q <= cur;
    if (cmd_i.enq) begin
      mem_q[cnt_q[IW-1:0]] <= '{pid: req_q.proc_id, wake_sec: req_q.time_seconds,
                                wake_ns: req_q.time_nanos, frame: req_q.frame_index,
                                page: req_q.page_num, rd: req_q.is_read,
                                wait_sec: '0, wait_ns: '0};
    end
    if (cmd_i.shift) mem_q[idx_q] <= nxt;
    if (cmd_i.wait_upd) mem_q[idx_q] <= upd;
    if (cmd_i.emit) rsp_q <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

### test/timed_wait_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// timed_wait_queue_unit_tb
// Self-checking bench for the timed wait queue: directed corner cases for
// each operation, then random traffic, checked against a behavioural queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_wait_queue_unit_tb;
  import twq_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  twq_req_t req_i = '0;
  logic     valid_o;
  twq_rsp_t rsp_o;

  int errors = 0;
  int cycles = 0;
  bit idle_en = 1'b1;

  twq_entry_t queue_model[$];
  twq_rsp_t   pending_rsp[$];

  timed_wait_queue_unit #(.QUEUE_DEPTH(DEPTH)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .valid_o(valid_o), .rsp_o(rsp_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic twq_rsp_t take_at(int k);
    twq_rsp_t r;
    r = '0;
    r.status = ST_OK;
    r.found = 1'b1;
    r.out_proc_id = queue_model[k].pid;
    r.out_wake_seconds = queue_model[k].wake_sec;
    r.out_wake_nanos = queue_model[k].wake_ns;
    r.out_frame_index = queue_model[k].frame;
    r.out_page_index = queue_model[k].page;
    r.out_is_read = queue_model[k].rd;
    r.out_waited_seconds = queue_model[k].wait_sec;
    r.out_waited_nanos = queue_model[k].wait_ns;
    queue_model.delete(k);
    return r;
  endfunction

  function automatic twq_rsp_t predict_queue(twq_req_t q);
    twq_rsp_t   r;
    twq_entry_t e;
    logic [63:0] sum, secs;
    r = '0;
    r.status = ST_NONE;
    case (twq_op_e'(q.operation))
      OP_ENQ: begin
        if (queue_model.size() >= DEPTH) r.status = ST_FULL;
        else begin
          e = '0;
          e.pid = q.proc_id; e.wake_sec = q.time_seconds; e.wake_ns = q.time_nanos;
          e.frame = q.frame_index; e.page = q.page_num; e.rd = q.is_read;
          queue_model.push_back(e);
          r.status = ST_OK;
        end
      end
      OP_DEQ: if (queue_model.size() > 0) r = take_at(0);
      OP_READY:
        for (int i = 0; i < queue_model.size(); i++)
          if (queue_model[i].wake_sec < q.time_seconds ||
              (queue_model[i].wake_sec == q.time_seconds &&
               queue_model[i].wake_ns <= q.time_nanos)) begin
            r = take_at(i);
            break;
          end
      OP_BY_ID:
        for (int i = 0; i < queue_model.size(); i++)
          if (queue_model[i].pid == q.proc_id) begin
            r = take_at(i);
            break;
          end
      OP_WAIT: begin
        foreach (queue_model[i]) begin
          sum = 64'(queue_model[i].wait_ns) + 64'(q.elapsed_nanos);
          secs = 64'(queue_model[i].wait_sec) + sum / 64'd1000000000;
          queue_model[i].wait_ns = 30'(sum % 64'd1000000000);
          queue_model[i].wait_sec = secs > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : secs[31:0];
        end
        r.status = ST_OK;
      end
      default: r.status = ST_NONE;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    twq_rsp_t e;
    if (rst_ni && valid_o) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected transaction: nothing expected");
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        check_field("status", 64'(e.status), 64'(rsp_o.status));
        check_field("found", 64'(e.found), 64'(rsp_o.found));
        check_field("out_proc_id", 64'(e.out_proc_id), 64'(rsp_o.out_proc_id));
        check_field("out_wake_seconds", 64'(e.out_wake_seconds),
                    64'(rsp_o.out_wake_seconds));
        check_field("out_wake_nanos", 64'(e.out_wake_nanos), 64'(rsp_o.out_wake_nanos));
        check_field("out_frame_index", 64'(e.out_frame_index),
                    64'(rsp_o.out_frame_index));
        check_field("out_page_index", 64'(e.out_page_index), 64'(rsp_o.out_page_index));
        check_field("out_is_read", 64'(e.out_is_read), 64'(rsp_o.out_is_read));
        check_field("out_waited_seconds", 64'(e.out_waited_seconds),
                    64'(rsp_o.out_waited_seconds));
        check_field("out_waited_nanos", 64'(e.out_waited_nanos),
                    64'(rsp_o.out_waited_nanos));
      end
    end
  end

  // Drives one transaction; start stays high between back-to-back sends.
  task automatic send_req(twq_req_t q);
    while (idle_en && $urandom_range(99) < 27) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= q;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_rsp.push_back(predict_queue(q));
  endtask

  function automatic twq_req_t rand_req(twq_op_e op);
    twq_req_t q;
    q.operation = op;
    q.proc_id = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(7));
    q.time_seconds = $urandom_range(3) == 0 ? $urandom : $urandom_range(5);
    q.time_nanos = $urandom_range(1) ? 30'($urandom) : 30'($urandom_range(999999999));
    q.frame_index = 8'($urandom);
    q.page_num = 6'($urandom);
    q.is_read = 1'($urandom);
    q.elapsed_nanos = $urandom_range(3) == 0 ? 30'($urandom) :
                      30'($urandom_range(999999999));
    return q;
  endfunction

  task automatic drain_queue();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_full_and_empty();
    twq_req_t q;
    q = rand_req(OP_DEQ);
    send_req(q);
    for (int i = 0; i < DEPTH + 1; i++) begin
      q = rand_req(OP_ENQ);
      q.proc_id = (i == 0) ? 16'hFFFF : 16'(i);
      q.time_seconds = (i == 1) ? 32'hFFFF_FFFF : 32'(i);
      q.time_nanos = (i == 2) ? 30'h3FFF_FFFF : 30'(i == 3 ? 999999999 : 0);
      send_req(q);
    end
  endtask

  task automatic test_wait_and_removal();
    twq_req_t q;
    q = rand_req(OP_WAIT); q.elapsed_nanos = 30'd999999999; send_req(q);
    q = rand_req(OP_WAIT); q.elapsed_nanos = 30'h3FFF_FFFF; send_req(q);
    q = rand_req(OP_READY); q.time_seconds = 32'd3; q.time_nanos = 30'd0; send_req(q);
    q = rand_req(OP_READY); q.time_seconds = 32'd1; q.time_nanos = 30'd0; send_req(q);
    q = rand_req(OP_BY_ID); q.proc_id = 16'd9; send_req(q);
    q = rand_req(OP_BY_ID); q.proc_id = 16'd1234; send_req(q);
    q = rand_req(OP_RSVD5); send_req(q);
    q = rand_req(OP_RSVD7); send_req(q);
    q = rand_req(OP_DEQ); send_req(q);
  endtask

  task automatic test_wait_saturation();
    twq_req_t q;
    drain_queue();
    for (int i = 0; i < 10; i++) begin
      q = rand_req(OP_WAIT);
      q.elapsed_nanos = 30'h3FFF_FFFF;
      send_req(q);
    end
  endtask

  task automatic test_random(int count);
    twq_req_t q;
    int r;
    for (int n = 0; n < count; n++) begin
      if (n == count / 3) idle_en = 1'b0;
      if (n == count / 2) begin
        idle_en = 1'b1;
        drain_queue();
      end
      r = $urandom_range(99);
      if (r < 35) q = rand_req(OP_ENQ);
      else if (r < 50) q = rand_req(OP_DEQ);
      else if (r < 68) q = rand_req(OP_READY);
      else if (r < 85) q = rand_req(OP_BY_ID);
      else if (r < 96) q = rand_req(OP_WAIT);
      else q = rand_req(twq_op_e'($urandom_range(7)));
      send_req(q);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_full_and_empty();
    test_wait_and_removal();
    test_wait_saturation();
    test_random(1020);
    drain_queue();
    repeat (2 * DEPTH + 10) @(posedge clk_i);
    if (errors == 0 && pending_rsp.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/twq_pkg.sv
hw/rtl/twq_ctrl.sv
hw/rtl/twq_dp.sv
hw/rtl/timed_wait_queue_unit.sv
test/timed_wait_queue_unit_tb.sv
